/* src/assert_macros.svh */
// Assertion macros shared by the RTL of the FDT structure token parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that prop holds at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("assertion failed");
// Check that cond never holds at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

/* src/fdtp_pkg.sv */
// Types and constants of the FDT structure token parser.
`default_nettype none
package fdtp_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned KIND_W  = 4;
	localparam int unsigned VB_W    = 3;
	localparam int unsigned TDATA_W = 104;

	localparam logic [WORD_W-1:0] TOK_BEGIN   = 32'd1;
	localparam logic [WORD_W-1:0] TOK_ENDNODE = 32'd2;
	localparam logic [WORD_W-1:0] TOK_PROP    = 32'd3;
	localparam logic [WORD_W-1:0] TOK_NOP     = 32'd4;
	localparam logic [WORD_W-1:0] TOK_END     = 32'd9;

	localparam logic [VB_W-1:0] WORD_BYTES = 3'd4;

	typedef enum logic [2:0] {
		PH_TOKEN = 3'd0,
		PH_NAME  = 3'd1,
		PH_LEN   = 3'd2,
		PH_OFF   = 3'd3,
		PH_DATA  = 3'd4,
		PH_HALT  = 3'd5
	} phase_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_WAIT      = 4'd0,
		KIND_NODE_BEG  = 4'd1,
		KIND_NAME      = 4'd2,
		KIND_NODE_END  = 4'd3,
		KIND_PROP_HDR  = 4'd4,
		KIND_PROP_DATA = 4'd5,
		KIND_NOP       = 4'd6,
		KIND_END       = 4'd7,
		KIND_ERROR     = 4'd8,
		KIND_IGNORED   = 4'd9
	} kind_t;

	typedef struct packed {
		phase_t            phase;
		logic [WORD_W-1:0] remaining;
		logic [WORD_W-1:0] held_len;
	} pstate_t;

	typedef struct packed {
		kind_t             kind;
		logic [WORD_W-1:0] payload;
		logic [VB_W-1:0]   valid_bytes;
		logic [WORD_W-1:0] prop_length;
		logic [WORD_W-1:0] name_offset;
		logic              last;
	} res_t;

endpackage
`default_nettype wire

/* src/fdtp_decode.sv */
// Word classifier and next-state logic of the FDT structure token parser.
`default_nettype none
module fdtp_decode (
	input  wire logic                      start_req,
	input  wire logic [fdtp_pkg::WORD_W-1:0] word,
	input  wire fdtp_pkg::pstate_t         cur,
	output fdtp_pkg::pstate_t              nxt,
	output fdtp_pkg::res_t                 res
);
	import fdtp_pkg::*;

	pstate_t         st;
	logic [VB_W-1:0] name_cnt;
	logic [VB_W-1:0] data_vb;
	logic [WORD_W-1:0] rem_after;

	// start drops all state before the word is looked at
	always_comb begin
		if (start_req) begin
			st = '{phase: PH_TOKEN, remaining: '0, held_len: '0};
		end else begin
			st = cur;
		end
	end

	// name bytes before the first zero byte, most significant byte first
	always_comb begin
		if (word[31:24] == 8'd0) begin
			name_cnt = 3'd0;
		end else if (word[23:16] == 8'd0) begin
			name_cnt = 3'd1;
		end else if (word[15:8] == 8'd0) begin
			name_cnt = 3'd2;
		end else if (word[7:0] == 8'd0) begin
			name_cnt = 3'd3;
		end else begin
			name_cnt = WORD_BYTES;
		end
	end

	assign data_vb   = (st.remaining < WORD_W'(WORD_BYTES)) ? st.remaining[VB_W-1:0]
		: WORD_BYTES;
	assign rem_after = st.remaining - WORD_W'(data_vb);

	always_comb begin
		nxt = st;
		res = '{kind: KIND_WAIT, payload: '0, valid_bytes: '0,
			prop_length: '0, name_offset: '0, last: 1'b0};
		case (st.phase)
			PH_TOKEN: begin
				case (word)
					TOK_BEGIN: begin
						res.kind  = KIND_NODE_BEG;
						nxt.phase = PH_NAME;
					end
					TOK_ENDNODE: res.kind = KIND_NODE_END;
					TOK_PROP: begin
						res.kind  = KIND_WAIT;
						nxt.phase = PH_LEN;
					end
					TOK_NOP: res.kind = KIND_NOP;
					TOK_END: begin
						res.kind  = KIND_END;
						nxt.phase = PH_HALT;
					end
					default: begin
						res.kind    = KIND_ERROR;
						res.payload = word;
						nxt.phase   = PH_HALT;
					end
				endcase
			end
			PH_NAME: begin
				res.kind        = KIND_NAME;
				res.payload     = word;
				res.valid_bytes = name_cnt;
				if (name_cnt != WORD_BYTES) begin
					res.last  = 1'b1;
					nxt.phase = PH_TOKEN;
				end
			end
			PH_LEN: begin
				nxt.held_len = word;
				nxt.phase    = PH_OFF;
			end
			PH_OFF: begin
				res.kind        = KIND_PROP_HDR;
				res.prop_length = st.held_len;
				res.name_offset = word;
				nxt.remaining   = st.held_len;
				if (st.held_len == '0) begin
					res.last  = 1'b1;
					nxt.phase = PH_TOKEN;
				end else begin
					nxt.phase = PH_DATA;
				end
			end
			PH_DATA: begin
				res.kind        = KIND_PROP_DATA;
				res.payload     = word;
				res.valid_bytes = data_vb;
				nxt.remaining   = rem_after;
				if (rem_after == '0) begin
					res.last  = 1'b1;
					nxt.phase = PH_TOKEN;
				end
			end
			default: begin
				res.kind  = KIND_IGNORED;
				nxt.phase = PH_HALT;
			end
		endcase
	end

endmodule
`default_nettype wire

/* src/fdt_struct_token_parser_unit.sv */
// Top level of the FDT structure token parser: input stage, state, result register.
// An accepted beat passes through the input register and then the result register before it shows at the master port.
// Throughput: one word per cycle, one result beat per word; the input register and the
// result register each load whenever the stage after them is empty or being drained.
// Reset (arst_n low, asynchronous) empties both stages and sets the parser to
// expect a token with zero remaining and held length.
`default_nettype none
`include "assert_macros.svh"
module fdt_struct_token_parser_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// slave side: tdata[31:0] word; tuser[0] start_req
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire logic [fdtp_pkg::WORD_W-1:0]  s_axis_tdata,
	input  wire logic                         s_axis_tuser,
	// master side: tdata[31:0] payload, [34:32] valid_bytes, [66:35] prop_length,
	// [98:67] name_offset, [103:99] zero; tuser[3:0] kind; tlast last
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	output logic [fdtp_pkg::TDATA_W-1:0]      m_axis_tdata,
	output logic [fdtp_pkg::KIND_W-1:0]       m_axis_tuser,
	output logic                              m_axis_tlast
);
	import fdtp_pkg::*;

	// input stage
	logic              valid_s1;
	logic              start_s1;
	logic [WORD_W-1:0] word_s1;

	// parser state
	pstate_t state_q;
	pstate_t state_nxt;

	// result register
	logic res_valid_s2;
	res_t res_s2;
	res_t res_nxt;

	logic out_free;
	logic advance;

	// the result register takes a new beat when empty or being drained
	assign out_free      = !res_valid_s2 || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || advance;

	// capture the input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			start_s1 <= s_axis_tuser;
			word_s1  <= s_axis_tdata;
		end
	end

	fdtp_decode u_decode (
		.start_req (start_s1),
		.word      (word_s1),
		.cur       (state_q),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	// advance the parser state only when the word moves on to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_TOKEN, remaining: '0, held_len: '0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_axis_tvalid = res_valid_s2;
	assign m_axis_tuser  = res_s2.kind;
	assign m_axis_tlast  = res_s2.last;
	assign m_axis_tdata  = {5'd0, res_s2.name_offset, res_s2.prop_length,
		res_s2.valid_bytes, res_s2.payload};

	// data phase always has bytes left to deliver
	`ASSERT_PROP(a_data_has_bytes, clk, arst_n,
		(state_q.phase == PH_DATA) |-> (state_q.remaining != '0))
	// the remaining count is cleared everywhere outside the data phase
	`ASSERT_PROP(a_rem_idle_zero, clk, arst_n,
		(state_q.phase != PH_DATA) |-> (state_q.remaining == '0))
	// a data beat carries at least one byte and never more than a word
	`ASSERT_NEVER(a_data_vb_range, clk, arst_n,
		res_valid_s2 && (res_s2.kind == KIND_PROP_DATA) &&
		((res_s2.valid_bytes == 3'd0) || (res_s2.valid_bytes > WORD_BYTES)))
	// a halted parser leaves halt only through a start beat
	`ASSERT_PROP(a_halt_sticky, clk, arst_n,
		($past(state_q.phase) == PH_HALT) && $past(advance) && !$past(start_s1)
		|-> (state_q.phase == PH_HALT))

endmodule
`default_nettype wire

/* tb/sv/fdt_token_checker.sv */
// Checker for the FDT structure token parser: predicts each result beat and compares it.
module fdt_token_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	input  wire logic                          s_axis_tready,
	input  wire logic [fdtp_pkg::WORD_W-1:0]   s_axis_tdata,
	input  wire logic                          s_axis_tuser,
	input  wire logic                          m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	input  wire logic [fdtp_pkg::TDATA_W-1:0]  m_axis_tdata,
	input  wire logic [fdtp_pkg::KIND_W-1:0]   m_axis_tuser,
	input  wire logic                          m_axis_tlast,
	output int unsigned                        errors,
	output int unsigned                        pending
);
	import fdtp_pkg::*;

	// parser state as the predictor sees it
	phase_t            ph;
	logic [WORD_W-1:0] data_left;
	logic [WORD_W-1:0] len_hold;

	res_t        predicted_beats[$];
	int unsigned fail_count;
	int unsigned beat_idx;

	// Classify one structure word and advance the predicted parser state.
	function automatic res_t classify_word(input logic st, input logic [WORD_W-1:0] w);
		res_t        r;
		int unsigned n;
		bit          hit;
		r   = '0;
		n   = 0;
		hit = 1'b0;
		if (st) begin
			ph        = PH_TOKEN;
			data_left = '0;
			len_hold  = '0;
		end
		case (ph)
			PH_TOKEN: begin
				case (w)
					TOK_BEGIN: begin
						r.kind = KIND_NODE_BEG;
						ph     = PH_NAME;
					end
					TOK_ENDNODE: r.kind = KIND_NODE_END;
					TOK_PROP: begin
						r.kind = KIND_WAIT;
						ph     = PH_LEN;
					end
					TOK_NOP: r.kind = KIND_NOP;
					TOK_END: begin
						r.kind = KIND_END;
						ph     = PH_HALT;
					end
					default: begin
						r.kind    = KIND_ERROR;
						r.payload = w;
						ph        = PH_HALT;
					end
				endcase
			end
			PH_NAME: begin
				// count name bytes ahead of the terminating zero, first byte in the MSBs
				for (int b = 0; b < 4; b++) begin
					if (!hit) begin
						if (w[31-8*b -: 8] == 8'h00)
							hit = 1'b1;
						else
							n++;
					end
				end
				r.kind        = KIND_NAME;
				r.payload     = w;
				r.valid_bytes = n[VB_W-1:0];
				if (hit) begin
					r.last = 1'b1;
					ph     = PH_TOKEN;
				end
			end
			PH_LEN: begin
				r.kind   = KIND_WAIT;
				len_hold = w;
				ph       = PH_OFF;
			end
			PH_OFF: begin
				r.kind        = KIND_PROP_HDR;
				r.prop_length = len_hold;
				r.name_offset = w;
				data_left     = len_hold;
				if (len_hold == '0) begin
					r.last = 1'b1;
					ph     = PH_TOKEN;
				end else begin
					ph = PH_DATA;
				end
			end
			PH_DATA: begin
				r.kind        = KIND_PROP_DATA;
				r.payload     = w;
				r.valid_bytes = (data_left < WORD_W'(WORD_BYTES)) ? data_left[VB_W-1:0]
					: WORD_BYTES;
				data_left     = data_left - WORD_W'(r.valid_bytes);
				if (data_left == '0) begin
					r.last = 1'b1;
					ph     = PH_TOKEN;
				end
			end
			default: begin
				r.kind = KIND_IGNORED;
				ph     = PH_HALT;
			end
		endcase
		return r;
	endfunction

	task automatic check_field(input string what, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t: beat %0d %s expected 0x%0h got 0x%0h",
				$time, beat_idx, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			predicted_beats.delete();
			ph         = PH_TOKEN;
			data_left  = '0;
			len_hold   = '0;
			fail_count = 0;
			beat_idx   = 0;
			pending <= 0;
			errors  <= 0;
		end else begin
			// compare the result beat first; its word was accepted, and its prediction queued, at an earlier edge
			if (m_axis_tvalid && m_axis_tready) begin
				if (predicted_beats.size() == 0) begin
					fail_count++;
					$display("%0t: beat %0d expected none got kind %0d payload 0x%0h",
						$time, beat_idx, m_axis_tuser, m_axis_tdata[31:0]);
				end else begin
					want = predicted_beats.pop_front();
					check_field("kind", WORD_W'(want.kind), WORD_W'(m_axis_tuser));
					check_field("payload", want.payload, m_axis_tdata[31:0]);
					check_field("valid_bytes", WORD_W'(want.valid_bytes),
						WORD_W'(m_axis_tdata[34:32]));
					check_field("prop_length", want.prop_length, m_axis_tdata[66:35]);
					check_field("name_offset", want.name_offset, m_axis_tdata[98:67]);
					check_field("last", WORD_W'(want.last), WORD_W'(m_axis_tlast));
				end
				beat_idx++;
			end
			if (s_axis_tvalid && s_axis_tready)
				predicted_beats.push_back(classify_word(s_axis_tuser, s_axis_tdata));
			pending <= predicted_beats.size();
			errors  <= fail_count;
		end
	end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top for the FDT structure token parser: stimulus, stalls and verdict.
module tb_top;
	import fdtp_pkg::*;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [WORD_W-1:0]   s_axis_tdata  = '0;
	logic                s_axis_tuser  = 1'b0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [TDATA_W-1:0]  m_axis_tdata;
	logic [KIND_W-1:0]   m_axis_tuser;
	logic                m_axis_tlast;

	int unsigned errors;
	int unsigned pending;

	// sender burst bookkeeping
	int unsigned burst_left = 0;
	int unsigned words_sent = 0;

	// receiver stall pattern
	int unsigned stall_mode = 0;
	int unsigned seg_left   = 0;
	int unsigned stall_tick = 0;

	fdt_struct_token_parser_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	fdt_token_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.errors        (errors),
		.pending       (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Receiver: switch between always ready, coin flips, long stalls and a fixed period.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (seg_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				seg_left   = $urandom_range(5, 80);
			end else begin
				seg_left--;
			end
			stall_tick++;
			case (stall_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				2: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: m_axis_tready <= (stall_tick % 3 != 0);
			endcase
		end
	end

	// Send one word; open a new burst after a gap when the current one is used up.
	task automatic put(input logic st, input logic [WORD_W-1:0] w);
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 250)
				: $urandom_range(1, 20);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= w;
		s_axis_tuser  <= st;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		burst_left--;
		words_sent++;
		if (burst_left == 0)
			s_axis_tvalid <= 1'b0;
	endtask

	// Hold the sender until every predicted beat has come out.
	task automatic hold_until_drained();
		if (burst_left != 0) begin
			s_axis_tvalid <= 1'b0;
			burst_left = 0;
		end
		do @(posedge clk); while (pending != 0);
	endtask

	// Emit a node name: nonzero bytes, the zero terminator, then padding.
	task automatic put_name(output bit cut);
		int unsigned len, pos;
		logic [WORD_W-1:0] w;
		bit junk_pad;
		cut      = 1'b0;
		len      = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 14);
		junk_pad = ($urandom_range(0, 3) == 0);
		pos      = 0;
		forever begin
			w = '0;
			for (int b = 0; b < 4; b++) begin
				if (pos < len)
					w[31-8*b -: 8] = 8'($urandom_range(1, 255));
				else if (pos > len && junk_pad)
					w[31-8*b -: 8] = 8'($urandom);
				pos++;
			end
			put(1'b0, w);
			if (pos > len)
				break;
			// drop the rest of a long name now and then; the next start cuts in
			if ($urandom_range(0, 19) == 0) begin
				cut = 1'b1;
				break;
			end
		end
	endtask

	// Emit a property: token, length, name offset and the data words.
	task automatic put_prop(output bit cut);
		int unsigned r, nwords;
		logic [WORD_W-1:0] plen;
		cut = 1'b0;
		r   = $urandom_range(0, 99);
		if (r < 10)
			plen = '0;
		else if (r < 80)
			plen = $urandom_range(1, 16);
		else if (r < 97)
			plen = $urandom_range(17, 64);
		else
			plen = 32'h8000_0000 | $urandom;
		put(1'b0, TOK_PROP);
		if ($urandom_range(0, 39) == 0) begin
			cut = 1'b1;
			return;
		end
		put(1'b0, plen);
		if ($urandom_range(0, 39) == 0) begin
			cut = 1'b1;
			return;
		end
		put(1'b0, $urandom);
		if (plen > 64 || $urandom_range(0, 49) == 0) begin
			// truncate the data; a huge length could never be sent in full
			cut    = 1'b1;
			nwords = $urandom_range(0, 3);
		end else begin
			nwords = (plen + 3) / 4;
		end
		repeat (nwords) put(1'b0, $urandom);
	endtask

	// Emit one structure block, mostly well formed, sometimes broken or cut short.
	task automatic put_block();
		int unsigned depth, steps, r;
		bit cut;
		depth = 0;
		cut   = 1'b0;
		if ($urandom_range(0, 14) == 0) begin
			// garbage in the first token slot, then words that should be ignored
			put(1'b1, $urandom);
			repeat ($urandom_range(0, 3)) put(1'b0, $urandom);
			return;
		end
		put(1'b1, TOK_BEGIN);
		put_name(cut);
		steps = $urandom_range(3, 40);
		while (steps != 0 && !cut) begin
			steps--;
			r = $urandom_range(0, 99);
			if (r < 20 && depth < 6) begin
				put(1'b0, TOK_BEGIN);
				put_name(cut);
				depth++;
			end else if (r < 40 && depth > 0) begin
				put(1'b0, TOK_ENDNODE);
				depth--;
			end else if (r < 85) begin
				put_prop(cut);
			end else if (r < 95) begin
				put(1'b0, TOK_NOP);
			end else if (r < 98) begin
				// unknown token, then halted words
				put(1'b0, $urandom);
				repeat ($urandom_range(0, 3)) put(1'b0, $urandom);
				cut = 1'b1;
			end else begin
				cut = 1'b1;
			end
		end
		if (cut)
			return;
		repeat (depth + 1) put(1'b0, TOK_ENDNODE);
		put(1'b0, TOK_END);
		repeat ($urandom_range(0, 3)) put(1'b0, $urandom);
	endtask

	initial begin
		int unsigned next_drain;
		@(posedge arst_n);

		// directed words
		put(1'b1, TOK_BEGIN);
		put(1'b0, 32'h6162_6364);       // four name bytes, no terminator yet
		put(1'b0, 32'h6566_6700);       // three bytes then the terminator
		put(1'b0, TOK_BEGIN);
		put(1'b0, 32'h00FF_FFFF);       // empty name with junk padding
		put(1'b0, TOK_BEGIN);
		put(1'b0, 32'h4100_FFFF);
		put(1'b0, TOK_PROP);
		put(1'b0, 32'h0000_0000);       // zero-length property
		put(1'b0, 32'hFFFF_FFFF);
		put(1'b0, TOK_PROP);
		put(1'b0, 32'd5);
		put(1'b0, 32'h0000_0000);
		put(1'b0, 32'hFFFF_FFFF);
		put(1'b0, 32'h1234_5678);       // single byte left, final data word
		put(1'b0, TOK_NOP);
		put(1'b0, TOK_ENDNODE);
		put(1'b0, TOK_PROP);
		put(1'b0, 32'hFFFF_FFFF);       // maximum length
		put(1'b0, 32'h8000_0001);
		put(1'b0, 32'hA5A5_5A5A);
		put(1'b1, TOK_END);             // restart in the data phase, end at once
		put(1'b0, TOK_BEGIN);           // halted: ignored
		put(1'b1, 32'hFFFF_FFFF);       // unknown token
		put(1'b0, 32'h0000_0000);       // halted: ignored
		put(1'b1, 32'h0000_0000);       // zero is no token either
		hold_until_drained();

		// random structure blocks
		next_drain = words_sent + 600;
		while (words_sent < 1830) begin
			put_block();
			if (words_sent >= next_drain) begin
				hold_until_drained();
				next_drain = words_sent + 600;
			end
		end

		hold_until_drained();
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("fdt_struct_token_parser_unit test passed");
		end else begin
			$display("fdt_struct_token_parser_unit test failed");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("fdt_struct_token_parser_unit test failed");
		$finish;
	end

endmodule
